FILE: rtl/core/ecgpk_pkg.sv
package ecgpk_pkg;

    localparam int GUARD_BITS    = 8;
    localparam int ALPHA_BITS    = 17;
    localparam int ALPHA_FRAC    = 16;
    localparam int THR_BITS      = 16;
    localparam int CFG_DATA_BITS = 17;
    localparam int CFG_ADDR_BITS = 1;
    localparam int RATE_BITS     = 16;
    localparam int RATE_NUM_BITS = 34;

    localparam logic [ALPHA_BITS-1:0]    ALPHA_ONE   = 17'd65536;
    localparam logic [ALPHA_BITS-1:0]    ALPHA_RESET = 17'd6554;
    localparam logic [RATE_NUM_BITS-1:0] RATE_NUM    = 34'd15360000000;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_ALPHA  = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_THRESH = 1'd1;

    typedef struct packed {
        logic seed;
        logic last;
    } t_kind;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

FILE: rtl/core/ecgpk_front.sv
module ecgpk_front #(
    parameter int AMP_BITS  = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [AMP_BITS-1:0]  i_amp,
    input  logic [TIME_BITS-1:0] i_time,
    input  logic                 i_last,
    output logic                 o_valid,
    input  logic                 i_pop,
    output logic [AMP_BITS-1:0]  o_amp,
    output logic [TIME_BITS-1:0] o_time,
    output ecgpk_pkg::t_kind     o_kind
);

    localparam int QDEPTH = 2;
    localparam int PTR_BITS = $clog2(QDEPTH);

    logic [AMP_BITS-1:0]   r_amp  [QDEPTH];
    logic [TIME_BITS-1:0]  r_time [QDEPTH];
    ecgpk_pkg::t_kind      r_kind [QDEPTH];
    logic [PTR_BITS-1:0]   r_wptr;
    logic [PTR_BITS-1:0]   r_rptr;
    logic [PTR_BITS:0]     r_count;
    logic                  r_in_record;
    logic                  n_push;
    logic                  n_pop;

    assign o_ready = (r_count < (PTR_BITS + 1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign n_push  = i_valid && o_ready;
    assign n_pop   = i_pop && o_valid;
    assign o_amp   = r_amp[r_rptr];
    assign o_time  = r_time[r_rptr];
    assign o_kind  = r_kind[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_count     <= '0;
            r_in_record <= 1'b0;
        end else begin
            if (n_push) begin
                r_amp[r_wptr]       <= i_amp;
                r_time[r_wptr]      <= i_time;
                r_kind[r_wptr].seed <= !r_in_record;
                r_kind[r_wptr].last <= i_last;
                r_wptr              <= r_wptr + 1'b1;
                r_in_record         <= !i_last;
            end
            if (n_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({n_push, n_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/core/ecgpk_rate_div.sv
module ecgpk_rate_div #(
    parameter int NUM_BITS = 51,
    parameter int DEN_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [NUM_BITS-1:0]                 i_num,
    input  logic [DEN_BITS-1:0]                 i_den,
    output ecgpk_pkg::t_div_status              o_status,
    output logic [ecgpk_pkg::RATE_BITS-1:0]     o_quot
);

    localparam int QB     = ecgpk_pkg::RATE_BITS;
    localparam int HI_BITS = NUM_BITS - QB;
    localparam int CMP_BITS = (HI_BITS > DEN_BITS) ? HI_BITS : DEN_BITS;
    localparam int CNT_BITS = $clog2(QB + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DEN_BITS-1:0] r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [QB-1:0]       r_low;
    logic [QB-1:0]       r_q;
    logic [CMP_BITS-1:0] n_hi;
    logic [CMP_BITS-1:0] n_den_ext;
    logic [DEN_BITS:0]   n_trial;
    logic                n_ge;

    assign n_hi      = CMP_BITS'(i_num[NUM_BITS-1:QB]);
    assign n_den_ext = CMP_BITS'(i_den);
    assign n_trial   = {r_rem, r_low[QB-1]};
    assign n_ge      = (n_trial >= {1'b0, r_den});

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= i_den;
                r_low <= i_num[QB-1:0];
                if (n_hi >= n_den_ext) begin
                    r_q    <= '1;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_rem  <= n_hi[DEN_BITS-1:0];
                    r_q    <= '0;
                    r_cnt  <= CNT_BITS'(QB);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= n_ge ? DEN_BITS'(n_trial - {1'b0, r_den}) : n_trial[DEN_BITS-1:0];
                r_q   <= {r_q[QB-2:0], n_ge};
                r_low <= {r_low[QB-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/core/ecgpk_back.sv
module ecgpk_back #(
    parameter int AMP_BITS        = 16,
    parameter int TIME_BITS       = 32,
    parameter int PEAK_COUNT_BITS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [ecgpk_pkg::CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [ecgpk_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic                                    i_q_valid,
    output logic                                    o_q_pop,
    input  logic [AMP_BITS-1:0]                     i_q_amp,
    input  logic [TIME_BITS-1:0]                    i_q_time,
    input  ecgpk_pkg::t_kind                        i_q_kind,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [AMP_BITS-1:0]                     o_famp,
    output logic                                    o_peak,
    output logic [TIME_BITS-1:0]                    o_ptime,
    output logic                                    o_rate_valid,
    output logic [ecgpk_pkg::RATE_BITS-1:0]         o_rate,
    output logic                                    o_last
);

    localparam int GB        = ecgpk_pkg::GUARD_BITS;
    localparam int AB        = ecgpk_pkg::ALPHA_BITS;
    localparam int AF        = ecgpk_pkg::ALPHA_FRAC;
    localparam int TB        = ecgpk_pkg::THR_BITS;
    localparam int RB        = ecgpk_pkg::RATE_BITS;
    localparam int ACC_BITS  = AMP_BITS + GB;
    localparam int DIFF_BITS = ACC_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + AB + 1;
    localparam int CMP_BITS  = ((ACC_BITS > TB + GB) ? ACC_BITS : TB + GB) + 1;
    localparam int MUL_BITS  = ecgpk_pkg::RATE_NUM_BITS + PEAK_COUNT_BITS;
    localparam int NUM_BITS  = ((MUL_BITS > TIME_BITS) ? MUL_BITS : TIME_BITS) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_UPD,
        S_RATE,
        S_DIV,
        S_OUT
    } t_state;

    t_state                         r_state;
    logic [AB-1:0]                  r_alpha;
    logic signed [TB-1:0]           r_thr;
    logic signed [ACC_BITS-1:0]     r_x;
    logic [TIME_BITS-1:0]           r_time;
    ecgpk_pkg::t_kind               r_kind;
    logic signed [DIFF_BITS-1:0]    r_diff;
    logic signed [PROD_BITS-1:0]    r_prod;
    logic signed [ACC_BITS-1:0]     r_acc;
    logic signed [ACC_BITS-1:0]     r_prev1;
    logic signed [ACC_BITS-1:0]     r_prev2;
    logic [TIME_BITS-1:0]           r_tprev1;
    logic [1:0]                     r_seen;
    logic [PEAK_COUNT_BITS-1:0]     r_pcount;
    logic [TIME_BITS-1:0]           r_tfirst;
    logic [TIME_BITS-1:0]           r_tlast;
    logic [NUM_BITS-1:0]            r_num;
    logic [AMP_BITS-1:0]            r_famp;
    logic                           r_pk;
    logic [TIME_BITS-1:0]           r_pt;
    logic                           r_rv;
    logic [RB-1:0]                  r_rate;
    logic                           r_rlast;
    logic                           r_ovalid;
    logic [AMP_BITS-1:0]            r_o_famp;
    logic                           r_o_peak;
    logic [TIME_BITS-1:0]           r_o_ptime;
    logic                           r_o_rv;
    logic [RB-1:0]                  r_o_rate;
    logic                           r_o_last;

    logic [AB-1:0]                  n_alpha;
    logic signed [ACC_BITS-1:0]     n_x;
    logic signed [DIFF_BITS-1:0]    n_diff;
    logic signed [PROD_BITS-1:0]    n_rnd;
    logic signed [PROD_BITS-1:0]    n_step;
    logic signed [ACC_BITS-1:0]     n_acc;
    logic signed [CMP_BITS-1:0]     n_thr;
    logic signed [CMP_BITS-1:0]     n_prev1;
    logic                           n_peak;
    logic [PEAK_COUNT_BITS-1:0]     n_pcount;
    logic signed [ACC_BITS:0]       n_fr;
    logic signed [AMP_BITS:0]       n_fq;
    logic [AMP_BITS-1:0]            n_famp;
    logic [TIME_BITS-1:0]           n_span;
    logic [NUM_BITS-1:0]            n_div_num;
    logic                           n_out_load;
    ecgpk_pkg::t_div_status         w_div_sts;
    logic [RB-1:0]                  w_div_q;

    always_comb begin
        n_alpha = (r_alpha > ecgpk_pkg::ALPHA_ONE) ? ecgpk_pkg::ALPHA_ONE : r_alpha;
        n_x     = $signed({i_q_amp, {GB{1'b0}}});
        n_diff  = DIFF_BITS'(n_x) - DIFF_BITS'(r_acc);
        n_rnd   = r_prod + PROD_BITS'(1 << (AF - 1));
        n_step  = n_rnd >>> AF;
        n_acc   = r_kind.seed ? r_x : r_acc + ACC_BITS'(n_step);
        n_thr   = CMP_BITS'($signed({r_thr, {GB{1'b0}}}));
        n_prev1 = CMP_BITS'(r_prev1);
        n_peak  = (r_seen == 2'd2) && (r_prev1 > r_prev2) && (r_prev1 > n_acc)
                  && (n_prev1 > n_thr);
        n_pcount = (n_peak && (r_pcount != '1)) ? r_pcount + 1'b1 : r_pcount;
        n_fr    = (ACC_BITS + 1)'(n_acc) + (ACC_BITS + 1)'(1 << (GB - 1));
        n_fq    = n_fr[ACC_BITS:GB];
        if (n_fq[AMP_BITS] != n_fq[AMP_BITS-1]) begin
            n_famp = {n_fq[AMP_BITS], {(AMP_BITS - 1){!n_fq[AMP_BITS]}}};
        end else begin
            n_famp = n_fq[AMP_BITS-1:0];
        end
        n_span    = r_tlast - r_tfirst;
        n_div_num = r_num + NUM_BITS'(n_span >> 1);
        n_out_load = (r_state == S_OUT) && (!r_ovalid || i_ready);
    end

    assign o_q_pop      = (r_state == S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_famp       = r_o_famp;
    assign o_peak       = r_o_peak;
    assign o_ptime      = r_o_ptime;
    assign o_rate_valid = r_o_rv;
    assign o_rate       = r_o_rate;
    assign o_last       = r_o_last;

    ecgpk_rate_div #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (TIME_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_RATE),
        .i_num    (n_div_num),
        .i_den    (n_span),
        .o_status (w_div_sts),
        .o_quot   (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_alpha  <= ecgpk_pkg::ALPHA_RESET;
            r_thr    <= '0;
            r_ovalid <= 1'b0;
            r_acc    <= '0;
            r_prev1  <= '0;
            r_prev2  <= '0;
            r_tprev1 <= '0;
            r_seen   <= '0;
            r_pcount <= '0;
            r_tfirst <= '0;
            r_tlast  <= '0;
            r_num    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    ecgpk_pkg::CFG_ALPHA:  r_alpha <= i_cfg_data[AB-1:0];
                    ecgpk_pkg::CFG_THRESH: r_thr   <= $signed(i_cfg_data[TB-1:0]);
                    default:               r_alpha <= r_alpha;
                endcase
            end
            if (n_out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_x     <= n_x;
                        r_time  <= i_q_time;
                        r_kind  <= i_q_kind;
                        r_diff  <= n_diff;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_BITS'(r_diff) * PROD_BITS'($signed({1'b0, n_alpha}));
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_acc    <= n_acc;
                    r_prev1  <= n_acc;
                    r_prev2  <= r_prev1;
                    r_tprev1 <= r_time;
                    if (r_seen != 2'd2) begin
                        r_seen <= r_seen + 1'b1;
                    end
                    if (n_peak) begin
                        if (r_pcount == '0) begin
                            r_tfirst <= r_tprev1;
                        end
                        r_tlast <= r_tprev1;
                        if ((r_pcount != '0) && (r_pcount != '1)) begin
                            r_num <= r_num + NUM_BITS'(ecgpk_pkg::RATE_NUM);
                        end
                    end
                    r_pcount <= n_pcount;
                    r_famp   <= n_famp;
                    r_pk     <= n_peak;
                    r_pt     <= n_peak ? r_tprev1 : '0;
                    r_rlast  <= r_kind.last;
                    r_rv     <= r_kind.last && (n_pcount >= PEAK_COUNT_BITS'(2));
                    r_rate   <= '0;
                    r_state  <= (r_kind.last && (n_pcount >= PEAK_COUNT_BITS'(2)))
                                ? S_RATE : S_OUT;
                end
                S_RATE: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_sts.done) begin
                        r_rate  <= w_div_q;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (n_out_load) begin
                        r_o_famp  <= r_famp;
                        r_o_peak  <= r_pk;
                        r_o_ptime <= r_pt;
                        r_o_rv    <= r_rv;
                        r_o_rate  <= r_rate;
                        r_o_last  <= r_rlast;
                        if (r_rlast) begin
                            r_acc    <= '0;
                            r_prev1  <= '0;
                            r_prev2  <= '0;
                            r_tprev1 <= '0;
                            r_seen   <= '0;
                            r_pcount <= '0;
                            r_tfirst <= '0;
                            r_tlast  <= '0;
                            r_num    <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/ecg_ema_peak_heart_rate_unit.sv
// ECG low-pass filter, peak detector and heart-rate estimator.
// Slave stream: one beat per sample; tdata carries amplitude and timestamp,
// tlast marks the final sample of a record.
// Master stream: one beat per sample; tdata carries filtered amplitude, the
// time of a peak found on the previous sample and the rate in Q8.8 bpm;
// tuser flags peak found and rate valid; tlast marks the record end.
// Configuration: write alpha (index 0) or threshold (index 1) while idle.
// An ordinary sample passes the filter steps subtract, multiply, update and
// output load in that order. A final sample with two or more peaks also
// passes a rate step and the one-bit-per-cycle rate divider before its
// output load.
// The core ends one sample before it pops the next. A two-deep input queue
// takes beats while the core works; the output register holds a result while
// the receiver stalls, so the core waits in its output step until it is taken.
// Reset (synchronous, active low) clears the queue, the record state and the
// output valid, and loads alpha 6554 and threshold 0.
module ecg_ema_peak_heart_rate_unit #(
    parameter int AMP_BITS        = 16,
    parameter int TIME_BITS       = 32,
    parameter int PEAK_COUNT_BITS = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_we,
    input  logic [ecgpk_pkg::CFG_ADDR_BITS-1:0]         i_cfg_addr,
    input  logic [ecgpk_pkg::CFG_DATA_BITS-1:0]         i_cfg_data,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // sample_amp, sample_time_us
    input  logic [((AMP_BITS + TIME_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic                                        s_axis_tlast,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // filtered_amp, peak_time_us, rate_bpm_q8
    output logic [((AMP_BITS + TIME_BITS + ecgpk_pkg::RATE_BITS + 7) / 8) * 8 - 1:0]
                                                        m_axis_tdata,
    // peak_found, rate_valid
    output logic [1:0]                                  m_axis_tuser,
    output logic                                        m_axis_tlast
);

    localparam int OUT_BITS = AMP_BITS + TIME_BITS + ecgpk_pkg::RATE_BITS;
    localparam int OUT_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    logic                               w_q_valid;
    logic                               w_q_pop;
    logic [AMP_BITS-1:0]                w_q_amp;
    logic [TIME_BITS-1:0]               w_q_time;
    ecgpk_pkg::t_kind                   w_q_kind;
    logic [AMP_BITS-1:0]                w_famp;
    logic                               w_peak;
    logic [TIME_BITS-1:0]               w_ptime;
    logic                               w_rv;
    logic [ecgpk_pkg::RATE_BITS-1:0]    w_rate;

    ecgpk_front #(
        .AMP_BITS  (AMP_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_amp   (s_axis_tdata[AMP_BITS-1:0]),
        .i_time  (s_axis_tdata[AMP_BITS+TIME_BITS-1:AMP_BITS]),
        .i_last  (s_axis_tlast),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_amp   (w_q_amp),
        .o_time  (w_q_time),
        .o_kind  (w_q_kind)
    );

    ecgpk_back #(
        .AMP_BITS        (AMP_BITS),
        .TIME_BITS       (TIME_BITS),
        .PEAK_COUNT_BITS (PEAK_COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_q_valid    (w_q_valid),
        .o_q_pop      (w_q_pop),
        .i_q_amp      (w_q_amp),
        .i_q_time     (w_q_time),
        .i_q_kind     (w_q_kind),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_famp       (w_famp),
        .o_peak       (w_peak),
        .o_ptime      (w_ptime),
        .o_rate_valid (w_rv),
        .o_rate       (w_rate),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_DATA_BITS'({w_rate, w_ptime, w_famp});
    assign m_axis_tuser = {w_rv, w_peak};

endmodule

FILE: rtl/core/ecgpk_checker.sv
module ecgpk_checker #(
    parameter int AMP_BITS  = 16,
    parameter int TIME_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    input  logic [((AMP_BITS + TIME_BITS + ecgpk_pkg::RATE_BITS + 7) / 8) * 8 - 1:0]
                                     m_axis_tdata,
    input  logic [1:0]               m_axis_tuser,
    input  logic                     m_axis_tlast
);

    localparam int RT_LO = AMP_BITS + TIME_BITS;
    localparam int RT_HI = RT_LO + ecgpk_pkg::RATE_BITS - 1;

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid not cleared by reset");

    a_rate_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
        else $error("rate valid outside record end");

    a_no_peak_zero_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
            (m_axis_tdata[RT_LO-1:AMP_BITS] == '0))
        else $error("peak time set without peak");

    a_no_rate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[1]) |-> (m_axis_tdata[RT_HI:RT_LO] == '0))
        else $error("rate set without rate valid");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output beat changed while stalled");

endmodule

bind ecg_ema_peak_heart_rate_unit ecgpk_checker #(
    .AMP_BITS  (AMP_BITS),
    .TIME_BITS (TIME_BITS)
) u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
